// ----- rtl/core/sst_pkg.sv -----
// Shared types and constants for the sorted set table.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 2;

  typedef logic [KIND_W-1:0]         kind_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_out_t;

  // Request codes; the unused code behaves as a lookup.
  localparam kind_t KIND_LOOKUP = 2'd0;
  localparam kind_t KIND_INSERT = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_set_table.sv -----
// Sorted set table: ascending distinct signed values in one RAM, lookup/insert/remove.
//
// Request channel (req_valid/req_stall) carries kind and value; response channel
// (rsp_valid/rsp_stall) returns one item per request: was_present, accepted, count.
// An item is taken when valid is high and stall is low.
// Entries live in a single-port-write, single-port-read RAM with a registered read
// port. A request runs as a sequence over that RAM:
//   - binary search: S_SRCH then S_CMP per step, up to ceil(log2(n+1)) steps for n elements,
//   - insert or remove: a one-place shift of the entries past the position,
//     one entry per cycle, then a drain step that writes the last shifted entry,
//   - a commit step (S_FIN) that writes an inserted entry and loads the response register.
// One request is in flight at a time; req_stall is high until the cycle after commit.
// The response register lets a new request start while the last response waits.
// If the receiver stalls, the commit waits until the response register is free.
// Reset empties the set (element count 0); RAM contents are not cleared and are never
// read beyond the count. Refused inserts (table full) return accepted = 0.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_table #(
  parameter int CAPACITY = 64
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           req_valid,
  output logic                          req_stall,
  input  wire  [sst_pkg::KIND_W-1:0]    kind,
  input  wire  signed [sst_pkg::VALUE_W-1:0] value,
  output logic                          rsp_valid,
  input  wire                           rsp_stall,
  output logic                          was_present,
  output logic                          accepted,
  output logic [sst_pkg::COUNT_W-1:0]   count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_SHIFT,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL
  } op_t;

  state_t state;
  op_t    op;

  sst_pkg::value_t mem [CAPACITY];
  sst_pkg::value_t rd_data;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  sst_pkg::value_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  sst_pkg::kind_t  kind_r;
  sst_pkg::value_t key_r;
  logic [CW-1:0]   elem_count;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   hi;
  logic [AW-1:0]   mid_r;
  logic            found;
  logic            res_accept;
  logic [CW-1:0]   scan;
  logic            issuing;
  logic            sh_pend;
  logic [AW-1:0]   sh_waddr;

  logic [CW:0]     mid_sum;
  logic [AW-1:0]   mid;
  logic            out_free;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   scan_end;

  op_t             dec_op;
  logic            dec_accept;
  logic            dec_shift;
  logic [CW-1:0]   dec_scan;

  assign mid_sum  = ({1'b0, lo} + {1'b0, hi}) >> 1;
  assign mid      = mid_sum[AW-1:0];
  assign out_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign scan_end = (op == OP_INS) ? lo : elem_count - CW'(1);

  always_comb begin
    case (op)
      OP_INS:  count_next = elem_count + CW'(1);
      OP_DEL:  count_next = elem_count - CW'(1);
      default: count_next = elem_count;
    endcase
  end

  // lo is the lower bound once the search ends; decide what the request does
  always_comb begin
    dec_op     = OP_NONE;
    dec_accept = 1'b1;
    dec_shift  = 1'b0;
    dec_scan   = lo + CW'(1);
    case (kind_r)
      sst_pkg::KIND_INSERT: begin
        if (!found) begin
          if (elem_count == CW'(CAPACITY)) begin
            dec_accept = 1'b0;
          end else begin
            dec_op    = OP_INS;
            dec_shift = (lo != elem_count);
            dec_scan  = elem_count - CW'(1);
          end
        end
      end
      sst_pkg::KIND_REMOVE: begin
        if (found) begin
          dec_op    = OP_DEL;
          dec_shift = (lo + CW'(1) != elem_count);
        end
      end
      default: begin
      end
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sh_waddr;
    mem_wdata = rd_data;
    mem_re    = 1'b0;
    mem_raddr = scan[AW-1:0];
    if (state == S_SRCH && lo < hi) begin
      mem_re    = 1'b1;
      mem_raddr = mid;
    end
    if (state == S_SHIFT) begin
      mem_re = issuing;
      mem_we = sh_pend;
    end
    if (state == S_FIN && out_free && op == OP_INS) begin
      mem_we    = 1'b1;
      mem_waddr = lo[AW-1:0];
      mem_wdata = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op         <= OP_NONE;
      elem_count <= '0;
      rsp_valid  <= 1'b0;
      issuing    <= 1'b0;
      sh_pend    <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_r <= kind;
            key_r  <= value;
            lo     <= '0;
            hi     <= elem_count;
            found  <= 1'b0;
            state  <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid_r <= mid;
            state <= S_CMP;
          end else begin
            op         <= dec_op;
            res_accept <= dec_accept;
            sh_pend    <= 1'b0;
            if (dec_shift) begin
              scan    <= dec_scan;
              issuing <= 1'b1;
              state   <= S_SHIFT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CMP: begin
          if (rd_data < key_r) begin
            lo <= CW'(mid_r) + CW'(1);
          end else begin
            hi <= CW'(mid_r);
          end
          // values are distinct, so a match is the lower bound itself
          if (rd_data == key_r) begin
            found <= 1'b1;
          end
          state <= S_SRCH;
        end
        S_SHIFT: begin
          if (issuing) begin
            sh_pend <= 1'b1;
            if (op == OP_INS) begin
              sh_waddr <= AW'(scan + CW'(1));
            end else begin
              sh_waddr <= AW'(scan - CW'(1));
            end
            if (scan == scan_end) begin
              issuing <= 1'b0;
            end else if (op == OP_INS) begin
              scan <= scan - CW'(1);
            end else begin
              scan <= scan + CW'(1);
            end
          end else begin
            // last shifted entry is written this cycle
            sh_pend <= 1'b0;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            elem_count  <= count_next;
            was_present <= found;
            accepted    <= res_accept;
            count       <= sst_pkg::COUNT_W'(count_next);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) elem_count <= CW'(CAPACITY))
    else $error("element count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !accepted) |-> (elem_count == CW'(CAPACITY)))
    else $error("insert refused while table not full");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && issuing) |-> (scan < elem_count))
    else $error("shift reads past the last element");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free && op == OP_INS)
    |=> (elem_count == $past(elem_count) + CW'(1)))
    else $error("insert did not grow the count");

endmodule

`default_nettype wire
